### hw/rtl/assert_macros.svh
// Assertion macros used by the event core of the sonar echo range qualifier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Checked at every rising clock edge while reset is low.
`define SEQR_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every rising clock edge, reset included.
`define SEQR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SEQR_ASSERT(lbl, clk, rst, prop, msg)
`define SEQR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### hw/rtl/seqr_pkg.sv
// Shared types and constants of the sonar echo range qualifier.
package seqr_pkg;

  localparam int OP_W    = 3;
  localparam int WIDTH_W = 16;
  localparam int COUNT_W = 8;
  localparam int DIST_W  = 10;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [OP_W-1:0] OP_TRIG_START = 3'd0;
  localparam logic [OP_W-1:0] OP_TRIG_END   = 3'd1;
  localparam logic [OP_W-1:0] OP_ECHO_RISE  = 3'd2;
  localparam logic [OP_W-1:0] OP_ECHO_FALL  = 3'd3;
  localparam logic [OP_W-1:0] OP_READ       = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_WIDTH      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_WIDTH      = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_LIMIT    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_WIDTH = 8'd3;

  localparam logic [WIDTH_W-1:0] MIN_WIDTH_RST      = 16'd354;
  localparam logic [WIDTH_W-1:0] MAX_WIDTH_RST      = 16'd59000;
  localparam logic [COUNT_W-1:0] ERROR_LIMIT_RST    = 8'd50;
  localparam logic [WIDTH_W-1:0] FALLBACK_WIDTH_RST = 16'd65490;

  typedef struct packed {
    logic [WIDTH_W-1:0] min_width;
    logic [WIDTH_W-1:0] max_width;
    logic [COUNT_W-1:0] error_limit;
    logic [WIDTH_W-1:0] fallback_width;
  } cfg_t;

  typedef struct packed {
    logic               trigger;
    logic               is_read;
    logic [WIDTH_W-1:0] width;
    logic               used_prev;
    logic               used_fb;
  } evt_result_t;

endpackage

### hw/rtl/seqr_cfg_regs.sv
// Configuration register file of the sonar echo range qualifier.
module seqr_cfg_regs
  import seqr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_width      <= MIN_WIDTH_RST;
      cfg.max_width      <= MAX_WIDTH_RST;
      cfg.error_limit    <= ERROR_LIMIT_RST;
      cfg.fallback_width <= FALLBACK_WIDTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MIN_WIDTH:      cfg.min_width      <= cfg_data;
        CFG_MAX_WIDTH:      cfg.max_width      <= cfg_data;
        CFG_ERROR_LIMIT:    cfg.error_limit    <= cfg_data[COUNT_W-1:0];
        CFG_FALLBACK_WIDTH: cfg.fallback_width <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### hw/rtl/seqr_event_core.sv
// Input register, event state and width qualification of the range qualifier.
`include "assert_macros.svh"
module seqr_event_core
  import seqr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [OP_W-1:0]    op,
  input  logic [WIDTH_W-1:0] timer_count,
  input  cfg_t               cfg,
  output logic               mid_valid,
  input  logic               mid_ready,
  output evt_result_t        mid
);

  logic               s1_valid;
  logic [OP_W-1:0]    s1_op;
  logic [WIDTH_W-1:0] s1_count;
  logic               s1_ready;
  logic               s1_adv;
  logic               s2_ready;

  logic               echo_measured, echo_measured_next;
  logic [WIDTH_W-1:0] echo_start, echo_start_next;
  logic [WIDTH_W-1:0] pulse_width, pulse_width_next;
  logic [WIDTH_W-1:0] last_good_width, last_good_width_next;
  logic [COUNT_W-1:0] bad_read_count, bad_read_count_next;
  logic               trigger_out, trigger_out_next;

  logic        out_of_window;
  evt_result_t res;

  assign s2_ready = !mid_valid || mid_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign s1_adv   = s1_valid && s2_ready;
  assign in_stall = !s1_ready;

  assign out_of_window = (pulse_width < cfg.min_width) || (pulse_width > cfg.max_width);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
    if (s1_ready && in_valid) begin
      s1_op    <= op;
      s1_count <= timer_count;
    end
  end

  always_comb begin
    echo_measured_next   = echo_measured;
    echo_start_next      = echo_start;
    pulse_width_next     = pulse_width;
    last_good_width_next = last_good_width;
    bad_read_count_next  = bad_read_count;
    trigger_out_next     = trigger_out;
    res                  = '0;
    case (s1_op)
      OP_TRIG_START: begin
        if (!echo_measured) begin
          pulse_width_next = '0;
        end
        trigger_out_next = 1'b1;
      end
      OP_TRIG_END: begin
        trigger_out_next   = 1'b0;
        echo_measured_next = 1'b0;
      end
      OP_ECHO_RISE: begin
        echo_start_next = s1_count;
      end
      OP_ECHO_FALL: begin
        pulse_width_next   = s1_count - echo_start;
        echo_measured_next = 1'b1;
      end
      OP_READ: begin
        res.is_read = 1'b1;
        if (out_of_window && (last_good_width != '0)) begin
          if (bad_read_count > cfg.error_limit) begin
            pulse_width_next = cfg.fallback_width;
            res.used_fb      = 1'b1;
          end else begin
            if (bad_read_count != '1) begin
              bad_read_count_next = bad_read_count + 1'b1;
            end
            pulse_width_next = last_good_width;
            res.used_prev    = 1'b1;
          end
        end else begin
          bad_read_count_next  = '0;
          last_good_width_next = pulse_width;
        end
        res.width = pulse_width_next;
      end
      default: ;
    endcase
    res.trigger = trigger_out_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      echo_measured   <= 1'b0;
      echo_start      <= '0;
      pulse_width     <= '0;
      last_good_width <= '0;
      bad_read_count  <= '0;
      trigger_out     <= 1'b0;
      mid_valid       <= 1'b0;
    end else begin
      if (s1_adv) begin
        echo_measured   <= echo_measured_next;
        echo_start      <= echo_start_next;
        pulse_width     <= pulse_width_next;
        last_good_width <= last_good_width_next;
        bad_read_count  <= bad_read_count_next;
        trigger_out     <= trigger_out_next;
      end
      if (s2_ready) begin
        mid_valid <= s1_adv;
      end
    end
    if (s1_adv) begin
      mid <= res;
    end
  end

  `SEQR_ASSERT(a_flags_exclusive, clk, rst, mid_valid |-> !(mid.used_prev && mid.used_fb), "both substitution flags set")
  `SEQR_ASSERT(a_flags_need_read, clk, rst, (mid_valid && (mid.used_prev || mid.used_fb)) |-> mid.is_read, "substitution flag on a non-read event")
  `SEQR_ASSERT(a_state_holds, clk, rst, !s1_adv |=> ($stable(bad_read_count) && $stable(pulse_width)), "event state changed without an event")
  `SEQR_ASSERT(a_count_after_good, clk, rst, (s1_adv && (s1_op == OP_READ) && !res.used_prev && !res.used_fb) |=> (bad_read_count == '0), "bad read count not cleared on a good read")

endmodule

### hw/rtl/seqr_range_div.sv
// Width to centimeter conversion and output register of the range qualifier.
module seqr_range_div
  import seqr_pkg::*;
#(
  parameter int unsigned TICKS_PER_CM = 118
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              mid_valid,
  output logic              mid_ready,
  input  evt_result_t       mid,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              trigger_level,
  output logic              distance_valid,
  output logic [DIST_W-1:0] distance_cm,
  output logic              used_previous,
  output logic              used_fallback
);

  // Exact reciprocal for every 16-bit dividend: m = ceil(2^(16+l) / d), l = ceil(log2 d).
  localparam int unsigned LOG_D  = $clog2(TICKS_PER_CM);
  localparam int unsigned SHIFT  = WIDTH_W + LOG_D;
  localparam int unsigned RECIP_W = WIDTH_W + 1;
  localparam int unsigned PROD_W  = WIDTH_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SHIFT) + 64'(TICKS_PER_CM) - 64'd1) / 64'(TICKS_PER_CM));

  logic [PROD_W-1:0]  product;
  logic [WIDTH_W-1:0] quotient;
  logic [DIST_W-1:0]  cm;

  assign mid_ready = !out_valid || !out_stall;

  assign product  = PROD_W'(mid.width) * PROD_W'(RECIP);
  assign quotient = WIDTH_W'(product >> SHIFT);
  assign cm       = (quotient > WIDTH_W'({DIST_W{1'b1}})) ? '1 : quotient[DIST_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (mid_ready) begin
      out_valid <= mid_valid;
    end
    if (mid_ready && mid_valid) begin
      trigger_level  <= mid.trigger;
      distance_valid <= mid.is_read;
      distance_cm    <= mid.is_read ? cm : '0;
      used_previous  <= mid.used_prev;
      used_fallback  <= mid.used_fb;
    end
  end

endmodule

### hw/rtl/sonar_echo_range_qualifier.sv
// Top level of the sonar echo range qualifier: event core, converter and registers.
// A request taken into the input register goes through the event core's result register
// and then the output register on its way to the result port.
// Throughput: one request per cycle while nothing stalls, set by the event state update.
// Pipeline: input register, state and qualification logic, then a multiply-based
// divide into the output register; each stage moves whenever the next one has room.
// Reset (rst, synchronous): empties the pipeline, clears all event state, and
// restores the four configuration registers to their default values.
module sonar_echo_range_qualifier
  import seqr_pkg::*;
#(
  parameter int unsigned TICKS_PER_CM = 118
) (
  input  logic                  clk,
  input  logic                  rst,
  // Event requests.
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [OP_W-1:0]       op,
  input  logic [WIDTH_W-1:0]    timer_count,
  // Results.
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  trigger_level,
  output logic                  distance_valid,
  output logic [DIST_W-1:0]     distance_cm,
  output logic                  used_previous,
  output logic                  used_fallback,
  // Configuration writes.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t        cfg;
  logic        mid_valid;
  logic        mid_ready;
  evt_result_t mid;

  // Configuration is always ready; an index beyond the register list is dropped.
  seqr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The event core keeps the trigger, echo and qualification state and settles
  // the final width of each read before it goes on to the converter.
  seqr_event_core u_core (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .timer_count (timer_count),
    .cfg         (cfg),
    .mid_valid   (mid_valid),
    .mid_ready   (mid_ready),
    .mid         (mid)
  );

  // The converter divides the width by the ticks per centimeter with an exact
  // reciprocal multiply and saturates at the top of the distance field.
  seqr_range_div #(
    .TICKS_PER_CM (TICKS_PER_CM)
  ) u_div (
    .clk            (clk),
    .rst            (rst),
    .mid_valid      (mid_valid),
    .mid_ready      (mid_ready),
    .mid            (mid),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .trigger_level  (trigger_level),
    .distance_valid (distance_valid),
    .distance_cm    (distance_cm),
    .used_previous  (used_previous),
    .used_fallback  (used_fallback)
  );

endmodule

### dv/sonar_echo_range_qualifier_tb.sv
// Self-checking testbench for the sonar echo range qualifier with a built-in event predictor.
`timescale 1ns / 100ps

module sonar_echo_range_qualifier_tb
  import seqr_pkg::*;
();

  // Same value as the block's default; the division below relies on it.
  localparam int unsigned TICKS_PER_CM = 118;
  // Three register stages between request and result, plus some margin.
  localparam int DRAIN_CYCLES = 8;
  localparam int unsigned DIST_MAX = (1 << DIST_W) - 1;

  // One result as seen on the output port.
  typedef struct packed {
    logic              trigger_level;
    logic              distance_valid;
    logic [DIST_W-1:0] distance_cm;
    logic              used_previous;
    logic              used_fallback;
  } reading_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [OP_W-1:0]       op = OP_TRIG_START;
  logic [WIDTH_W-1:0]    timer_count = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  trigger_level;
  logic                  distance_valid;
  logic [DIST_W-1:0]     distance_cm;
  logic                  used_previous;
  logic                  used_fallback;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  sonar_echo_range_qualifier #(
    .TICKS_PER_CM(TICKS_PER_CM)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .op            (op),
    .timer_count   (timer_count),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .trigger_level (trigger_level),
    .distance_valid(distance_valid),
    .distance_cm   (distance_cm),
    .used_previous (used_previous),
    .used_fallback (used_fallback),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Predictor copy of the configuration registers.
  logic [WIDTH_W-1:0] win_min;
  logic [WIDTH_W-1:0] win_max;
  logic [COUNT_W-1:0] bad_limit;
  logic [WIDTH_W-1:0] fb_width;

  // Predictor copy of the event state.
  logic               echo_seen;
  logic [WIDTH_W-1:0] rise_count;
  logic [WIDTH_W-1:0] width_now;
  logic [WIDTH_W-1:0] good_width;
  logic [COUNT_W-1:0] bad_reads;
  logic               trig_level;

  // Readings predicted for accepted requests, oldest first.
  reading_t pending_readings[$];

  int mismatches = 0;
  int items_sent = 0;
  // Percent chance per cycle that the sender holds back or the receiver stalls.
  int send_gap_pct = 0;
  int recv_gap_pct = 0;
  // When nonzero, the receiver stalls for this many more cycles unconditionally.
  int hold_off_left = 0;

  reading_t got_reading;
  reading_t want_reading;

  initial begin
    forever #10 clk = ~clk;
  end

  // A generous ceiling; a correct run needs only a small fraction of it.
  initial begin
    #2_000_000;
    $display("sonar_echo_range_qualifier test failed");
    $finish;
  end

  // Receiver side: random stalls, or a long unbroken hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      out_stall <= 1'b1;
      hold_off_left = hold_off_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_gap_pct);
    end
  end

  // Every result taken from the block is compared with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      got_reading = {trigger_level, distance_valid, distance_cm, used_previous, used_fallback};
      if (pending_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result with no pending request: trig=%0b valid=%0b cm=%0d",
                   $realtime, got_reading.trigger_level, got_reading.distance_valid,
                   got_reading.distance_cm);
          $display("%0t: result with no pending request: prev=%0b fb=%0b",
                   $realtime, got_reading.used_previous, got_reading.used_fallback);
        end
      end else begin
        want_reading = pending_readings.pop_front();
        if (got_reading !== want_reading) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: expected trig=%0b valid=%0b cm=%0d prev=%0b fb=%0b", $realtime,
                     want_reading.trigger_level, want_reading.distance_valid,
                     want_reading.distance_cm, want_reading.used_previous,
                     want_reading.used_fallback);
            $display("%0t: actual   trig=%0b valid=%0b cm=%0d prev=%0b fb=%0b", $realtime,
                     got_reading.trigger_level, got_reading.distance_valid,
                     got_reading.distance_cm, got_reading.used_previous,
                     got_reading.used_fallback);
          end
        end
      end
    end
  end

  // Applies one accepted event to the predictor state and queues the reading it yields.
  task automatic advance_ranger(input logic [OP_W-1:0] o, input logic [WIDTH_W-1:0] t);
    reading_t    r;
    logic        out_of_window;
    int unsigned cm;
    r = '0;
    case (o)
      OP_TRIG_START: begin
        // Without an echo since the last trigger the old width is stale.
        if (!echo_seen) width_now = '0;
        trig_level = 1'b1;
      end
      OP_TRIG_END: begin
        trig_level = 1'b0;
        echo_seen  = 1'b0;
      end
      OP_ECHO_RISE: rise_count = t;
      OP_ECHO_FALL: begin
        // The timer wraps, so the difference is taken modulo 2^16.
        width_now = t - rise_count;
        echo_seen = 1'b1;
      end
      OP_READ: begin
        out_of_window = (width_now < win_min) || (width_now > win_max);
        // Until a good width has been seen, every width is taken as good.
        if (out_of_window && good_width != '0) begin
          if (bad_reads > bad_limit) begin
            width_now       = fb_width;
            r.used_fallback = 1'b1;
          end else begin
            if (bad_reads != '1) bad_reads++;
            width_now       = good_width;
            r.used_previous = 1'b1;
          end
        end else begin
          bad_reads  = '0;
          good_width = width_now;
        end
        cm = width_now / TICKS_PER_CM;
        if (cm > DIST_MAX) cm = DIST_MAX;
        r.distance_cm    = cm[DIST_W-1:0];
        r.distance_valid = 1'b1;
      end
      default: ;  // Unused codes leave the state alone.
    endcase
    r.trigger_level = trig_level;
    pending_readings.push_back(r);
  endtask

  // Offers one event request and returns once the block has taken it.
  task automatic send_event(input logic [OP_W-1:0] o, input logic [WIDTH_W-1:0] t);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    op          <= o;
    timer_count <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_ranger(o, t);
    if (o <= OP_READ) items_sent++;
  endtask

  // Takes the request line down and waits until every predicted reading has come back.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write; only called while the block is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_MIN_WIDTH:      win_min   = data;
      CFG_MAX_WIDTH:      win_max   = data;
      CFG_ERROR_LIMIT:    bad_limit = data[COUNT_W-1:0];
      CFG_FALLBACK_WIDTH: fb_width  = data;
      default: ;  // Indexes past the last register are ignored.
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Echo widths aimed at the current window: mostly inside, some below, above and at the rails.
  function automatic logic [WIDTH_W-1:0] pick_width();
    int unsigned lo;
    int unsigned hi;
    lo = 32'(win_min);
    hi = 32'(win_max);
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return (lo <= hi) ? WIDTH_W'($urandom_range(hi, lo)) : WIDTH_W'($urandom);
      5:             return (lo > 0) ? WIDTH_W'($urandom_range(lo - 1, 0)) : '0;
      6:             return (hi < 65535) ? WIDTH_W'($urandom_range(65535, hi + 1)) : '1;
      7:             return WIDTH_W'($urandom);
      8:             return '0;
      default:       return '1;
    endcase
  endfunction

  // One measurement period with random content; now and then the echo or the trigger end is lost.
  task automatic ping_cycle();
    logic [WIDTH_W-1:0] t0;
    logic [WIDTH_W-1:0] w;
    int                 reads;
    t0    = WIDTH_W'($urandom);
    w     = pick_width();
    reads = $urandom_range(2, 1);
    send_event(OP_TRIG_START, WIDTH_W'($urandom));
    if ($urandom_range(5) != 0) send_event(OP_TRIG_END, WIDTH_W'($urandom));
    if ($urandom_range(7) != 0) begin
      send_event(OP_ECHO_RISE, t0);
      send_event(OP_ECHO_FALL, t0 + w);
    end
    repeat (reads) send_event(OP_READ, WIDTH_W'($urandom));
  endtask

  // A fresh window with a low error limit so that fallback substitution shows up often.
  // The upper data byte is junk on purpose for the 8-bit limit register.
  task automatic program_random_window();
    int unsigned lo;
    lo = $urandom_range(3000, 0);
    settle();
    write_reg(CFG_MIN_WIDTH, CFG_DATA_W'(lo));
    write_reg(CFG_MAX_WIDTH, CFG_DATA_W'($urandom_range(65535, lo)));
    write_reg(CFG_ERROR_LIMIT, {8'($urandom), 8'($urandom_range(6))});
    write_reg(CFG_FALLBACK_WIDTH, CFG_DATA_W'($urandom));
    write_reg(CFG_IDX_W'($urandom_range(255, 4)), CFG_DATA_W'($urandom));
  endtask

  // Walks the event types by hand at the default window: the first reads before any
  // good width, a wrapping echo, both window edges, unused op codes and timer rails.
  task automatic test_directed_events();
    send_event(OP_READ, 16'h0000);
    send_event(OP_TRIG_START, 16'hFFFF);
    send_event(OP_ECHO_RISE, 16'hFFFF);
    send_event(OP_ECHO_FALL, 16'h0010);
    send_event(OP_TRIG_END, 16'h0000);
    send_event(OP_READ, 16'hFFFF);
    send_event(OP_ECHO_RISE, 16'd1000);
    send_event(OP_ECHO_FALL, 16'd60000);
    send_event(OP_READ, 16'h5555);
    send_event(OP_ECHO_RISE, 16'd0);
    send_event(OP_ECHO_FALL, 16'd59001);
    send_event(OP_READ, 16'hAAAA);
    send_event(OP_ECHO_RISE, 16'd100);
    send_event(OP_ECHO_FALL, 16'd454);
    send_event(OP_READ, 16'h0001);
    send_event(OP_ECHO_RISE, 16'd0);
    send_event(OP_ECHO_FALL, 16'd353);
    send_event(OP_READ, 16'h8000);
    send_event(OP_TRIG_START, 16'h1234);
    send_event(3'd5, 16'hFFFF);
    send_event(3'd6, 16'h0000);
    send_event(3'd7, 16'hFFFF);
    send_event(OP_ECHO_FALL, 16'hFFFF);
    send_event(OP_READ, 16'h0000);
    send_event(OP_TRIG_END, 16'hFFFF);
  endtask

  // Register extremes: a window open to everything, then an inverted one that makes
  // every width bad, with a zero error limit and both fallback rails.
  task automatic test_window_extremes();
    settle();
    write_reg(CFG_MIN_WIDTH, 16'd0);
    write_reg(CFG_MAX_WIDTH, 16'hFFFF);
    write_reg(CFG_ERROR_LIMIT, 16'hA500);
    write_reg(CFG_FALLBACK_WIDTH, 16'hFFFF);
    write_reg(8'd4, 16'h0000);
    write_reg(8'hFF, 16'hFFFF);
    send_event(OP_ECHO_RISE, 16'd0);
    send_event(OP_ECHO_FALL, 16'd0);
    send_event(OP_READ, 16'd0);
    send_event(OP_ECHO_FALL, 16'hFFFF);
    send_event(OP_READ, 16'd0);
    settle();
    write_reg(CFG_MIN_WIDTH, 16'hFFFF);
    write_reg(CFG_MAX_WIDTH, 16'd0);
    send_event(OP_READ, 16'd0);
    send_event(OP_READ, 16'd0);
    send_event(OP_READ, 16'd0);
    settle();
    write_reg(CFG_FALLBACK_WIDTH, 16'd0);
    send_event(OP_READ, 16'd0);
    send_event(OP_READ, 16'd0);
    settle();
    write_reg(CFG_MIN_WIDTH, MIN_WIDTH_RST);
    write_reg(CFG_MAX_WIDTH, MAX_WIDTH_RST);
    send_event(OP_ECHO_FALL, 16'd1000);
    send_event(OP_READ, 16'd0);
  endtask

  // With the limit at its top the bad-read counter must stop at full scale rather than wrap;
  // lowering the limit by one afterwards shows where it stopped.
  task automatic test_bad_read_counter_saturation();
    settle();
    write_reg(CFG_ERROR_LIMIT, 16'h00FF);
    write_reg(CFG_MIN_WIDTH, 16'hFFFF);
    write_reg(CFG_MAX_WIDTH, 16'd0);
    repeat (260) send_event(OP_READ, WIDTH_W'($urandom));
    settle();
    write_reg(CFG_ERROR_LIMIT, 16'd254);
    send_event(OP_READ, WIDTH_W'($urandom));
    send_event(OP_READ, WIDTH_W'($urandom));
  endtask

  // Mostly well-formed measurement periods, with stray and unused events mixed in.
  task automatic test_random_events(input int n_items);
    int target;
    target = items_sent + n_items;
    while (items_sent < target) begin
      if ($urandom_range(9) < 8) begin
        ping_cycle();
      end else begin
        send_event(OP_W'($urandom_range(7)), WIDTH_W'($urandom));
      end
    end
  endtask

  // The receiver holds off for a long stretch while requests keep coming, so the
  // pipeline fills and the block has to stall its input.
  task automatic test_output_backpressure();
    hold_off_left = 150;
    repeat (8) ping_cycle();
  endtask

  initial begin
    win_min    = MIN_WIDTH_RST;
    win_max    = MAX_WIDTH_RST;
    bad_limit  = ERROR_LIMIT_RST;
    fb_width   = FALLBACK_WIDTH_RST;
    echo_seen  = 1'b0;
    rise_count = '0;
    width_now  = '0;
    good_width = '0;
    bad_reads  = '0;
    trig_level = 1'b0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // First idling phase: the sender is mostly busy and the receiver mostly stalled.
    send_gap_pct = 11;
    recv_gap_pct = 72;
    test_directed_events();
    test_window_extremes();
    test_bad_read_counter_saturation();
    program_random_window();
    test_random_events(230);

    // Second phase: the roles of the two sides are swapped.
    settle();
    send_gap_pct = 72;
    recv_gap_pct = 11;
    program_random_window();
    test_random_events(230);

    // Last phase: no idling at all, starting with a long receiver hold-off.
    settle();
    send_gap_pct = 0;
    recv_gap_pct = 0;
    test_output_backpressure();
    program_random_window();
    test_random_events(230);

    settle();
    if (mismatches == 0) begin
      $display("sonar_echo_range_qualifier test passed");
    end else begin
      $display("sonar_echo_range_qualifier test failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/seqr_pkg.sv
hw/rtl/seqr_cfg_regs.sv
hw/rtl/seqr_event_core.sv
hw/rtl/seqr_range_div.sv
hw/rtl/sonar_echo_range_qualifier.sv
dv/sonar_echo_range_qualifier_tb.sv
